### hdl/corq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corq_pkg: shared definitions of the credit-ordered ready queue
// Sizes, command and status codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package corq_pkg;

    localparam int CAPACITY   = 16;
    localparam int MAX_CREDIT = 100;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int THREAD_W = 8;
    localparam int CREDIT_W = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [THREAD_W-1:0] t_thread;
    typedef logic [CREDIT_W-1:0] t_credit;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_CHANGE = 2'd2;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_MISSING = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHDN,
        S_SCAN,
        S_SHUP,
        S_FINISH
    } t_state;

    // Slot store control from the sequencer
    typedef struct packed {
        logic    we;
        t_idx    waddr;
        t_thread wthread;
        t_credit wcredit;
        t_idx    raddr;
    } t_slot_ctl;

    // Slot store read data back to the sequencer and top level
    typedef struct packed {
        t_thread rthread;
        t_credit rcredit;
        t_thread head_thread;
        t_credit head_credit;
    } t_slot_rd;

    function automatic t_credit sat_credit(input t_credit c);
        if (int'(c) > MAX_CREDIT) begin
            return CREDIT_W'(MAX_CREDIT);
        end
        return c;
    endfunction

endpackage

### hdl/corq_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corq_slots: entry store of the ready queue
// One write port, one indexed read port and a fixed tap on the head slot.
// ----------------------------------------------------------------------------
module corq_slots
    import corq_pkg::*;
(
    input  logic      i_clk,
    input  t_slot_ctl i_ctl,
    output t_slot_rd  o_rd
);

    t_thread r_thread [CAPACITY];
    t_credit r_credit [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_thread[i_ctl.waddr] <= i_ctl.wthread;
            r_credit[i_ctl.waddr] <= i_ctl.wcredit;
        end
    end

    assign o_rd.rthread     = r_thread[i_ctl.raddr];
    assign o_rd.rcredit     = r_credit[i_ctl.raddr];
    assign o_rd.head_thread = r_thread[0];
    assign o_rd.head_credit = r_credit[0];

endmodule

### hdl/corq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corq_seq: command sequencer of the ready queue
// Walks the slots one per cycle to find, close up, search and open a gap.
// ----------------------------------------------------------------------------
module corq_seq
    import corq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_cmd      i_command,
    input  t_thread   i_thread_id,
    input  t_credit   i_credit,
    input  logic      i_out_free,
    input  t_slot_rd  i_rd,
    output t_slot_ctl o_ctl,
    output logic      o_idle,
    output logic      o_finish,
    output t_status   o_status,
    output t_cnt      o_occ
);

    t_state  r_state, n_state;
    t_cnt    r_idx, n_idx;
    t_cnt    r_pos, n_pos;
    t_cnt    r_occ, n_occ;
    t_cmd    r_cmd, n_cmd;
    t_thread r_id, n_id;
    t_credit r_cr, n_cr;
    t_status r_status, n_status;

    // Shared compare unit
    logic idx_lt_occ, next_lt_occ, idx_gt_pos, id_eq, credit_ge;

    assign idx_lt_occ  = r_idx < r_occ;
    assign next_lt_occ = (r_idx + CNT_W'(1)) < r_occ;
    assign idx_gt_pos  = r_idx > r_pos;
    assign id_eq       = i_rd.rthread == r_id;
    assign credit_ge   = i_rd.rcredit >= r_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_cr     <= n_cr;
        r_status <= n_status;
    end

    // Next state and working registers
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_occ    = r_occ;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_cr     = r_cr;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_command;
                    n_id     = i_thread_id;
                    n_cr     = sat_credit(i_credit);
                    n_idx    = '0;
                    n_status = ST_DONE;
                    case (i_command)
                        CMD_INSERT: begin
                            if (int'(r_occ) >= CAPACITY) begin
                                n_status = ST_FULL;
                                n_state  = S_FINISH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_REMOVE, CMD_CHANGE: n_state = S_FIND;
                        default:                n_state = S_FINISH;
                    endcase
                end
            end
            S_FIND: begin
                if (!idx_lt_occ) begin
                    n_status = ST_MISSING;
                    n_state  = S_FINISH;
                end else if (id_eq) begin
                    n_state = S_SHDN;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SHDN: begin
                if (next_lt_occ) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_occ = r_occ - CNT_W'(1);
                    if (r_cmd == CMD_CHANGE) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (idx_lt_occ && credit_ge) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_occ;
                    n_state = S_SHUP;
                end
            end
            S_SHUP: begin
                if (idx_gt_pos) begin
                    n_idx = r_idx - CNT_W'(1);
                end else begin
                    n_occ   = r_occ + CNT_W'(1);
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Store control and handshake outputs
    always_comb begin
        o_ctl.we      = 1'b0;
        o_ctl.waddr   = r_idx[IDX_W-1:0];
        o_ctl.wthread = i_rd.rthread;
        o_ctl.wcredit = i_rd.rcredit;
        o_ctl.raddr   = r_idx[IDX_W-1:0];
        o_idle        = 1'b0;
        o_finish      = 1'b0;
        case (r_state)
            S_IDLE: o_idle = 1'b1;
            S_SHDN: begin
                o_ctl.raddr = IDX_W'(r_idx + CNT_W'(1));
                o_ctl.we    = next_lt_occ;
            end
            S_SHUP: begin
                o_ctl.raddr = IDX_W'(r_idx - CNT_W'(1));
                o_ctl.we    = 1'b1;
                if (!idx_gt_pos) begin
                    o_ctl.wthread = r_id;
                    o_ctl.wcredit = r_cr;
                end
            end
            S_FINISH: o_finish = i_out_free;
            default: ;
        endcase
    end

    assign o_status = r_status;
    assign o_occ    = r_occ;

endmodule

### hdl/credit_ordered_ready_queue.sv
`timescale 1ns / 1ps
// Sequence: a full insert or unused command goes from acceptance straight to loading the
//   result; a change credit finds and closes up the entry, searches and opens a gap, then
//   loads the result; output stalls delay the load.
// Flow: one transaction at a time; the next is taken the cycle after the result
//   is registered.
// Reset: synchronous, active low; empties the queue, drops any pending result, stalls input.
// ----------------------------------------------------------------------------
// credit_ordered_ready_queue: stable sorted queue of thread entries
// Keeps entries in descending credit order, FIFO among equal credits, and
// answers each insert, remove or change-credit command with one result.
// ----------------------------------------------------------------------------
module credit_ordered_ready_queue
    import corq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [THREAD_W-1:0] i_thread_id,
    input  logic [CREDIT_W-1:0] i_credit,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_head_valid,
    output logic [THREAD_W-1:0] o_head_thread,
    output logic [CREDIT_W-1:0] o_head_credit,
    output logic [TOTAL_W-1:0]  o_entry_total
);

    t_slot_ctl slot_ctl;
    t_slot_rd  slot_rd;
    logic      seq_idle;
    logic      seq_finish;
    t_status   seq_status;
    t_cnt      seq_occ;
    logic      in_accept;
    logic      out_free;

    logic      r_out_valid;
    t_status   r_status;
    logic      r_head_valid;
    t_thread   r_head_thread;
    t_credit   r_head_credit;
    logic [TOTAL_W-1:0] r_total;

    // Take a new transaction only while the sequencer is idle and out of reset
    assign o_in_stall = !seq_idle || !i_rst_n;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The result register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    corq_slots u_slots (
        .i_clk (i_clk),
        .i_ctl (slot_ctl),
        .o_rd  (slot_rd)
    );

    corq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_command   (i_command),
        .i_thread_id (i_thread_id),
        .i_credit    (i_credit),
        .i_out_free  (out_free),
        .i_rd        (slot_rd),
        .o_ctl       (slot_ctl),
        .o_idle      (seq_idle),
        .o_finish    (seq_finish),
        .o_status    (seq_status),
        .o_occ       (seq_occ)
    );

    // Result register: hold until taken, load when the sequencer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the head snapshot; an empty queue reports zeros
    always_ff @(posedge i_clk) begin
        if (seq_finish) begin
            r_status <= seq_status;
            r_total  <= TOTAL_W'(seq_occ);
            if (seq_occ != '0) begin
                r_head_valid  <= 1'b1;
                r_head_thread <= slot_rd.head_thread;
                r_head_credit <= slot_rd.head_credit;
            end else begin
                r_head_valid  <= 1'b0;
                r_head_thread <= '0;
                r_head_credit <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_head_valid  = r_head_valid;
    assign o_head_thread = r_head_thread;
    assign o_head_credit = r_head_credit;
    assign o_entry_total = r_total;

endmodule

### test/ready_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_checker: result predictor and scoreboard for the ready queue
// Keeps a shadow copy of the credit-ordered queue, works out the reply to each
// accepted command and compares every accepted reply with the oldest one due.
// ----------------------------------------------------------------------------
module ready_queue_checker
    import corq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [THREAD_W-1:0] i_thread_id,
    input  logic [CREDIT_W-1:0] i_credit,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_head_valid,
    input  logic [THREAD_W-1:0] i_head_thread,
    input  logic [CREDIT_W-1:0] i_head_credit,
    input  logic [TOTAL_W-1:0]  i_entry_total,
    output int                  o_fail_count,
    output int                  o_outstanding
);

    typedef struct packed {
        t_status              status;
        logic                 head_valid;
        t_thread              head_thread;
        t_credit              head_credit;
        logic [TOTAL_W-1:0]   entry_total;
    } t_queue_reply;

    // Shadow queue: slot 0 is the head
    t_thread      held_thread [CAPACITY];
    t_credit      held_credit [CAPACITY];
    int           held_count = 0;
    t_queue_reply replies_due [$];
    int           fail_total = 0;

    // Place after the last entry whose credit is at least cr; caller
    // guarantees a free slot.
    function automatic void place_by_credit(input t_thread id, input t_credit cr);
        int pos;
        int k;
        pos = 0;
        while (pos < held_count && held_credit[pos] >= cr) pos++;
        for (k = held_count; k > pos; k--) begin
            held_thread[k] = held_thread[k-1];
            held_credit[k] = held_credit[k-1];
        end
        held_thread[pos] = id;
        held_credit[pos] = cr;
        held_count++;
    endfunction

    function automatic t_queue_reply apply_command(input t_cmd cmd, input t_thread id,
                                                   input t_credit cr_raw);
        t_queue_reply r;
        t_credit      cr;
        int           hit;
        int           k;
        cr = (int'(cr_raw) > MAX_CREDIT) ? t_credit'(MAX_CREDIT) : cr_raw;
        r.status = ST_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (held_count >= CAPACITY) r.status = ST_FULL;
                else place_by_credit(id, cr);
            end
            CMD_REMOVE, CMD_CHANGE: begin
                hit = -1;
                for (k = 0; k < held_count; k++) begin
                    if (hit < 0 && held_thread[k] == id) hit = k;
                end
                if (hit < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    for (k = hit; k + 1 < held_count; k++) begin
                        held_thread[k] = held_thread[k+1];
                        held_credit[k] = held_credit[k+1];
                    end
                    held_count--;
                    if (cmd == CMD_CHANGE) place_by_credit(id, cr);
                end
            end
            default: begin
                // unused code: leave the queue alone, report done
            end
        endcase
        r.head_valid  = (held_count > 0);
        r.head_thread = r.head_valid ? held_thread[0] : '0;
        r.head_credit = r.head_valid ? held_credit[0] : '0;
        r.entry_total = TOTAL_W'(held_count);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_reply want;
        if (!i_rst_n) begin
            held_count = 0;
            replies_due.delete();
        end else begin
            // Retire the reply first: it belongs to an earlier command
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, i_status);
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status",      8'(want.status),      8'(i_status));
                    check_field("head_valid",  8'(want.head_valid),  8'(i_head_valid));
                    check_field("head_thread", 8'(want.head_thread), 8'(i_head_thread));
                    check_field("head_credit", 8'(want.head_credit), 8'(i_head_credit));
                    check_field("entry_total", 8'(want.entry_total), 8'(i_entry_total));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(apply_command(i_command, i_thread_id, i_credit));
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= replies_due.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the credit-ordered ready queue
// Drives directed and random insert, remove and change-credit commands under
// several idling patterns; the checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import corq_pkg::*;

    // The block ignores this code; it has no name in the package
    localparam t_cmd CMD_UNUSED       = 2'd3;
    localparam int   RANDOM_PER_PHASE = 388;
    localparam int   HOLD_CYCLES      = 300;
    localparam int   DRAIN_CYCLES     = 80;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command     = '0;
    logic [THREAD_W-1:0] i_thread_id   = '0;
    logic [CREDIT_W-1:0] i_credit      = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic                o_head_valid;
    logic [THREAD_W-1:0] o_head_thread;
    logic [CREDIT_W-1:0] o_head_credit;
    logic [TOTAL_W-1:0]  o_entry_total;

    // Idling percentages for the sender and the receiver, per phase
    int idle_pct        = 0;
    int stall_pct       = 0;
    // Request a long receiver hold-off of this many cycles
    int hold_cycles_req = 0;
    int fail_count;
    int outstanding;

    credit_ordered_ready_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_thread_id   (i_thread_id),
        .i_credit      (i_credit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_head_valid  (o_head_valid),
        .o_head_thread (o_head_thread),
        .o_head_credit (o_head_credit),
        .o_entry_total (o_entry_total)
    );

    ready_queue_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_thread_id   (i_thread_id),
        .i_credit      (i_credit),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_head_valid  (o_head_valid),
        .i_head_thread (o_head_thread),
        .i_head_credit (o_head_credit),
        .i_entry_total (o_entry_total),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stall per cycle, or a long hold-off when requested.
    // The hold-off lets the block fill up and push back on its input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_cycles_req > 0) begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one command, after a random gap, and return at the edge that
    // accepts it. Valid is left high so a following transaction can go
    // back to back; it is only lowered when a gap is due.
    task automatic send_item(input t_cmd cmd, input t_thread id, input t_credit cr);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_thread_id <= id;
        i_credit    <= cr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold the input idle until every reply due has come back
    task automatic await_results;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int      k;
        int      phase;
        int      pick;
        int      run_left;
        bit      filling;
        t_cmd    cmd;
        t_thread id;
        t_credit cr;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed part ----
        // Remove and change on an empty queue: thread not found
        send_item(CMD_REMOVE, 8'h07, 7'd10);
        send_item(CMD_CHANGE, 8'h07, 7'd60);
        // Lowest id with zero credit, highest id with credit above the ceiling
        send_item(CMD_INSERT, 8'h00, 7'd0);
        send_item(CMD_INSERT, 8'hFF, 7'd127);
        // Equal credits keep arrival order
        send_item(CMD_INSERT, 8'h55, 7'd100);
        send_item(CMD_INSERT, 8'hAA, 7'd100);
        // Duplicate id further back; change must pick the one nearest the head
        send_item(CMD_INSERT, 8'h55, 7'd50);
        send_item(CMD_CHANGE, 8'h55, 7'd100);
        // Move the head to the tail, then re-place the last entry onto itself
        send_item(CMD_CHANGE, 8'hFF, 7'd0);
        send_item(CMD_CHANGE, 8'hFF, 7'd0);
        send_item(CMD_REMOVE, 8'h00, 7'd0);
        // Unused command code with every payload bit set
        send_item(CMD_UNUSED, 8'hFF, 7'h7F);
        // Fill to capacity with tied credits
        for (k = 0; k < 12; k++) begin
            send_item(CMD_INSERT, t_thread'(8'h10 + k), t_credit'((k % 4) * 30));
        end
        // Full queue: insert refused, change still works, absent id missing
        send_item(CMD_INSERT, 8'h99, 7'd70);
        send_item(CMD_CHANGE, 8'h13, 7'd127);
        send_item(CMD_REMOVE, 8'h99, 7'd0);
        await_results();

        // ---- Random part ----
        // Alternate fill-heavy and drain-heavy runs so the queue swings
        // between empty and full; ids mostly from a small pool so removes
        // and changes usually hit.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 78; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            if (phase == 0 || phase == 3) hold_cycles_req = HOLD_CYCLES;
            filling  = 1'b1;
            run_left = $urandom_range(20, 60);
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(20, 60);
                end
                run_left--;
                pick = $urandom_range(0, 99);
                if (filling) begin
                    cmd = (pick < 70) ? CMD_INSERT : (pick < 85) ? CMD_REMOVE :
                          (pick < 97) ? CMD_CHANGE : CMD_UNUSED;
                end else begin
                    cmd = (pick < 25) ? CMD_INSERT : (pick < 70) ? CMD_REMOVE :
                          (pick < 97) ? CMD_CHANGE : CMD_UNUSED;
                end
                id = ($urandom_range(0, 99) < 80) ? t_thread'($urandom_range(0, 19))
                                                  : t_thread'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick < 6)      cr = t_credit'($urandom_range(0, 4) * 25);
                else if (pick < 9) cr = t_credit'($urandom_range(0, 127));
                else               cr = $urandom_range(0, 1) ? 7'd127 : 7'd0;
                send_item(cmd, id, cr);
            end
            // Sender pauses here until the queue has answered everything
            await_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/corq_pkg.sv
hdl/corq_slots.sv
hdl/corq_seq.sv
hdl/credit_ordered_ready_queue.sv
test/ready_queue_checker.sv
test/testbench.sv
